// File: design/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared request codes, status codes and the cell command struct.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_FIND   = 3'd2;
    localparam logic [2:0] OP_SET    = 3'd3;
    localparam logic [2:0] OP_GET    = 3'd4;
    localparam logic [2:0] OP_REMOVE = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic capture;
        logic wr_append;
        logic wr_insert;
        logic wr_set;
        logic wr_remove;
    } cell_cmd_t;

endpackage

// File: design/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds an element and its registered match flag, and passes
// match, index and read data along the chain to its neighbors.
// ----------------------------------------------------------------------------
module ile_cell #(
    parameter int PW  = 5,
    parameter int IDX = 0
) (
    input  logic               clk,
    input  ile_pkg::cell_cmd_t cmd,
    input  logic [31:0]        key,
    input  logic [31:0]        data,
    input  logic [PW-1:0]      pos,
    input  logic [PW-1:0]      count,
    input  logic [31:0]        left_elem,
    input  logic [31:0]        right_elem,
    output logic [31:0]        elem,
    input  logic               seen_in,
    output logic               seen_out,
    input  logic [PW-1:0]      idx_in,
    output logic [PW-1:0]      idx_out,
    input  logic [31:0]        rd_in,
    output logic [31:0]        rd_out
);

    localparam logic [PW-1:0] IDX_V = PW'(IDX);
    localparam logic [PW-1:0] IDX_N = PW'(IDX + 1);

    logic [31:0] elem_reg;
    logic [31:0] elem_next;
    logic        match_reg;
    logic        first;

    assign elem     = elem_reg;
    assign seen_out = seen_in | match_reg;
    assign first    = match_reg & ~seen_in;
    assign idx_out  = idx_in | (first ? IDX_V : '0);
    assign rd_out   = rd_in | ((IDX_V == pos) ? elem_reg : 32'd0);

    always_comb
    begin
        elem_next = elem_reg;
        priority if (cmd.wr_append && IDX_V == count)
        begin
            elem_next = data;
        end
        else if (cmd.wr_insert && IDX_V == pos)
        begin
            elem_next = data;
        end
        else if (cmd.wr_insert && IDX_V > pos && IDX_V <= count)
        begin
            elem_next = left_elem;
        end
        else if (cmd.wr_set && IDX_V == pos)
        begin
            elem_next = data;
        end
        else if (cmd.wr_remove && seen_out && IDX_N < count)
        begin
            elem_next = right_elem;
        end
        else
        begin
            elem_next = elem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
        if (cmd.capture)
        begin
            match_reg <= (elem_reg == key) && (IDX_V < count);
        end
    end

endmodule

// File: design/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of signed 32-bit values held in a row of cells.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   request  | req_valid, req_stall | op, position, value
//   response | rsp_valid, rsp_stall | status, found_position, read_value,
//            |                      | length
//
// Two steps per item: the accept edge registers every cell's compare, a
// later edge shifts or writes the cells and loads the response register.
// The response register frees the request side; a stalled response holds
// the second step. Reset clears the count and handshake state only.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         op,
    input  logic [4:0]         position,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic [3:0]         found_position,
    output logic signed [31:0] read_value,
    output logic [4:0]         length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 5) ? CW : 5;
    localparam logic [PW-1:0] CAP_V = PW'(CAPACITY);

    logic              pend_reg;
    logic [2:0]        op_reg;
    logic [4:0]        pos_reg;
    logic [31:0]       val_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              rsp_valid_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [3:0]        fpos_reg;
    logic [3:0]        fpos_next;
    logic [31:0]       rval_reg;
    logic [31:0]       rval_next;

    logic              accept;
    logic              exec;
    logic [PW-1:0]     count_ext;
    logic [PW-1:0]     pos_ext;
    logic              full;
    logic              found;
    ile_pkg::cell_cmd_t cmd;

    logic [31:0]       elem_w [CAPACITY];
    logic              seen_w [CAPACITY+1];
    logic [PW-1:0]     idx_w  [CAPACITY+1];
    logic [31:0]       rd_w   [CAPACITY+1];

    assign accept    = req_valid & ~req_stall;
    assign req_stall = pend_reg;
    assign exec      = pend_reg & (~rsp_valid_reg | ~rsp_stall);

    assign count_ext = PW'(count_reg);
    assign pos_ext   = PW'(pos_reg);
    assign full      = count_ext >= CAP_V;
    assign found     = seen_w[CAPACITY];

    assign seen_w[0] = 1'b0;
    assign idx_w[0]  = '0;
    assign rd_w[0]   = 32'd0;

    always_comb
    begin
        cmd         = '0;
        cmd.capture = accept;
        count_next  = count_reg;
        status_next = ile_pkg::ST_OK;
        fpos_next   = 4'd0;
        rval_next   = 32'd0;
        unique case (op_reg)
            ile_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    status_next = ile_pkg::ST_FULL;
                end
                else
                begin
                    cmd.wr_append = exec;
                    count_next    = count_reg + CW'(1);
                end
            end
            ile_pkg::OP_INSERT:
            begin
                priority if (full)
                begin
                    status_next = ile_pkg::ST_FULL;
                end
                else if (pos_ext > count_ext)
                begin
                    status_next = ile_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.wr_insert = exec;
                    count_next    = count_reg + CW'(1);
                end
            end
            ile_pkg::OP_FIND:
            begin
                if (found)
                begin
                    fpos_next = idx_w[CAPACITY][3:0];
                end
                else
                begin
                    status_next = ile_pkg::ST_MISSING;
                end
            end
            ile_pkg::OP_SET:
            begin
                if (pos_ext >= count_ext)
                begin
                    status_next = ile_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.wr_set = exec;
                end
            end
            ile_pkg::OP_GET:
            begin
                if (pos_ext >= count_ext)
                begin
                    status_next = ile_pkg::ST_RANGE;
                end
                else
                begin
                    rval_next = rd_w[CAPACITY];
                end
            end
            ile_pkg::OP_REMOVE:
            begin
                if (found)
                begin
                    cmd.wr_remove = exec;
                    count_next    = count_reg - CW'(1);
                end
                else
                begin
                    status_next = ile_pkg::ST_MISSING;
                end
            end
            default:
            begin
                status_next = ile_pkg::ST_OK;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [31:0] left_w;
        logic [31:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = 32'd0;
        end
        else
        begin : g_mid
            assign left_w = elem_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = 32'd0;
        end
        else
        begin : g_inner
            assign right_w = elem_w[i+1];
        end

        ile_cell #(
            .PW  (PW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .key        (value),
            .data       (val_reg),
            .pos        (pos_ext),
            .count      (count_ext),
            .left_elem  (left_w),
            .right_elem (right_w),
            .elem       (elem_w[i]),
            .seen_in    (seen_w[i]),
            .seen_out   (seen_w[i+1]),
            .idx_in     (idx_w[i]),
            .idx_out    (idx_w[i+1]),
            .rd_in      (rd_w[i]),
            .rd_out     (rd_w[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg <= 1'b1;
            end
            else if (exec)
            begin
                pend_reg <= 1'b0;
            end

            if (exec)
            begin
                rsp_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            pos_reg <= position;
            val_reg <= value;
        end
        if (exec)
        begin
            status_reg <= status_next;
            fpos_reg   <= fpos_next;
            rval_reg   <= rval_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign found_position = fpos_reg;
    assign read_value     = $signed(rval_reg);
    assign length         = 5'(PW'(count_reg));

endmodule
